FILE: rtl/core/sorted_range_set_merger_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted range set merger assertion macros
// Shared property forms for the concurrent checks of the block. They rely on
// a clock named clk and an active-low reset named rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_RANGE_SET_MERGER_TOP_DEFINES_SVH
`define SORTED_RANGE_SET_MERGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/srsm_pkg.sv
// ----------------------------------------------------------------------------
// Sorted range set merger package
// Types, codes and default sizes shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package srsm_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_RESULTS    = 32;
    localparam int IO_BITS        = 32;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_POP     = 2'd2,
        REQ_EXTRACT = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ZERO  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_POP,
        S_EXT_FIRST,
        S_EXT_RUN
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_DELETE
    } cell_op_t;

    // Per-cell compare results handed to the neighbor and the controller.
    typedef struct packed {
        logic after;
        logic match;
    } cell_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_range_set_merger_top.sv
// ----------------------------------------------------------------------------
// Sorted range set merger top level
// A chain of cells keeps ranges sorted by low end; requests add, delete, pop
// or extract merged runs, with results through a registered output.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata                                 tuser
// s_axis    in   [31:0] range_start, [63:32] range_end [1:0] req_type
// m_axis    out  [31:0] out_low, [63:32] out_high      [1:0] status, tlast = last
//
// Add and pop are accepted in idle, then move the cell chain in their own state;
// delete removes every matching entry before loading the result. Extract loads
// the head cell, then streams one cell per cycle unless a closing run waits on
// a stalled output. Reset clears the state, counters and output valid; the cell
// contents need no clearing. A stalled output holds the controller in its
// result step; the next request is accepted as soon as the block is back in idle.
`default_nettype none

module sorted_range_set_merger_top
    import srsm_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*IO_BITS-1:0] s_tdata,   // range_start, range_end
    input  wire logic [1:0]           s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [2*IO_BITS-1:0] m_tdata,   // out_low, out_high
    output logic      [1:0]           m_tuser,   // status
    output logic                      m_tlast
);

`include "sorted_range_set_merger_top_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RUN_W = $clog2(MAX_RESULTS);
    localparam logic [IO_BITS-1:0] IN_MASK = (VALUE_BITS >= IO_BITS) ? '1 :
        IO_BITS'((65'(1) << VALUE_BITS) - 65'(1));

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        rem_next;
    logic [RUN_W-1:0]        runs_reg;
    logic [RUN_W-1:0]        runs_next;
    logic [VALUE_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0]   key_high_reg;
    logic [VALUE_BITS-1:0]   key_high_next;
    logic                    zero_reg;
    logic                    zero_next;
    logic [VALUE_BITS-1:0]   cl_reg;
    logic [VALUE_BITS-1:0]   cl_next;
    logic [VALUE_BITS-1:0]   ch_reg;
    logic [VALUE_BITS-1:0]   ch_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic [IO_BITS-1:0]      out_low_reg;
    logic [IO_BITS-1:0]      out_low_next;
    logic [IO_BITS-1:0]      out_high_reg;
    logic [IO_BITS-1:0]      out_high_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic                    s_accept;
    logic                    out_free;
    logic                    emit;
    status_t                 emit_status;
    logic [VALUE_BITS-1:0]   emit_low;
    logic [VALUE_BITS-1:0]   emit_high;
    logic                    emit_last;
    cell_op_t                cell_op;

    logic [VALUE_BITS-1:0]   in_a;
    logic [VALUE_BITS-1:0]   in_b;
    logic                    any_match;
    logic                    merge;
    logic                    runs_at_limit;

    logic [VALUE_BITS-1:0]   cell_low  [CAPACITY];
    logic [VALUE_BITS-1:0]   cell_high [CAPACITY];
    cell_flags_t             cell_flags [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] prev_low;
        logic [VALUE_BITS-1:0] prev_high;
        logic                  prev_after;
        logic [VALUE_BITS-1:0] next_low;
        logic [VALUE_BITS-1:0] next_high;

        if (i == 0)
        begin : g_head
            assign prev_low   = '0;
            assign prev_high  = '0;
            assign prev_after = 1'b0;
        end
        else
        begin : g_body
            assign prev_low   = cell_low[i-1];
            assign prev_high  = cell_high[i-1];
            assign prev_after = cell_flags[i-1].after;
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_low  = '0;
            assign next_high = '0;
        end
        else
        begin : g_link
            assign next_low  = cell_low[i+1];
            assign next_high = cell_high[i+1];
        end

        srsm_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CAPACITY   (CAPACITY),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .count      (count_reg),
            .key        (key_reg),
            .key_high   (key_high_reg),
            .prev_low   (prev_low),
            .prev_high  (prev_high),
            .prev_after (prev_after),
            .next_low   (next_low),
            .next_high  (next_high),
            .low        (cell_low[i]),
            .high       (cell_high[i]),
            .flags      (cell_flags[i])
        );

        assign match_vec[i] = cell_flags[i].match;
    end

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    assign s_tready      = (state_reg == S_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign out_free      = !out_valid_reg || m_tready;
    assign in_a          = VALUE_BITS'(s_tdata[IO_BITS-1:0] & IN_MASK);
    assign in_b          = VALUE_BITS'(s_tdata[2*IO_BITS-1:IO_BITS] & IN_MASK);
    assign any_match     = |match_vec;
    assign merge         = ({1'b0, cell_low[0]} <=
                            ({1'b0, ch_reg} + (VALUE_BITS + 1)'(1)));
    assign runs_at_limit = (runs_reg == RUN_W'(MAX_RESULTS - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (req_type_t'(s_tuser))
                        REQ_ADD:     state_next = S_ADD;
                        REQ_DELETE:  state_next = S_DEL;
                        REQ_POP:     state_next = S_POP;
                        REQ_EXTRACT: state_next = S_EXT_FIRST;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD, S_POP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_DEL:
            begin
                if (!any_match && out_free)
                    state_next = S_IDLE;
            end
            S_EXT_FIRST:
            begin
                if (count_reg != '0)
                    state_next = S_EXT_RUN;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_EXT_RUN:
            begin
                if (rem_reg == '0)
                begin
                    if (out_free)
                        state_next = S_IDLE;
                end
                else if (!merge && out_free && runs_at_limit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs of the controller
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next    = count_reg;
        rem_next      = rem_reg;
        runs_next     = runs_reg;
        key_next      = key_reg;
        key_high_next = key_high_reg;
        zero_next     = zero_reg;
        cl_next       = cl_reg;
        ch_next       = ch_reg;
        cell_op       = CELL_HOLD;
        emit          = 1'b0;
        emit_status   = STAT_OK;
        emit_low      = '0;
        emit_high     = '0;
        emit_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    zero_next = (in_a == '0) || (in_b == '0);
                    if (req_type_t'(s_tuser) == REQ_ADD)
                    begin
                        key_next      = (in_a < in_b) ? in_a : in_b;
                        key_high_next = (in_a < in_b) ? in_b : in_a;
                    end
                    else
                    begin
                        key_next = in_a;
                    end
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (zero_reg)
                        emit_status = STAT_ZERO;
                    else if (count_reg >= CNT_W'(CAPACITY))
                        emit_status = STAT_FULL;
                    else
                    begin
                        cell_op    = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_DEL:
            begin
                if (any_match)
                begin
                    cell_op    = CELL_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (count_reg == '0)
                        emit_status = STAT_EMPTY;
                    else
                    begin
                        emit_low   = cell_low[0];
                        cell_op    = CELL_SHIFT;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_EXT_FIRST:
            begin
                if (count_reg != '0)
                begin
                    cl_next   = cell_low[0];
                    ch_next   = cell_high[0];
                    cell_op   = CELL_SHIFT;
                    rem_next  = count_reg - CNT_W'(1);
                    runs_next = '0;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = STAT_EMPTY;
                end
            end
            S_EXT_RUN:
            begin
                if (rem_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_low   = cl_reg;
                        emit_high  = ch_reg;
                        count_next = '0;
                    end
                end
                else if (merge)
                begin
                    if (cell_high[0] > ch_reg)
                        ch_next = cell_high[0];
                    cell_op  = CELL_SHIFT;
                    rem_next = rem_reg - CNT_W'(1);
                end
                else if (out_free)
                begin
                    emit      = 1'b1;
                    emit_low  = cl_reg;
                    emit_high = ch_reg;
                    // Once the result limit is reached the run closing now is
                    // the final one shown, and the rest of the table is dropped.
                    emit_last = runs_at_limit;
                    if (runs_at_limit)
                        count_next = '0;
                    else
                    begin
                        cl_next   = cell_low[0];
                        ch_next   = cell_high[0];
                        cell_op   = CELL_SHIFT;
                        rem_next  = rem_reg - CNT_W'(1);
                        runs_next = runs_reg + RUN_W'(1);
                    end
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_low_next    = IO_BITS'(emit_low);
            out_high_next   = IO_BITS'(emit_high);
            out_last_next   = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            runs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            runs_reg      <= runs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        key_high_reg   <= key_high_next;
        zero_reg       <= zero_next;
        cl_reg         <= cl_next;
        ch_reg         <= ch_next;
        out_status_reg <= out_status_next;
        out_low_reg    <= out_low_next;
        out_high_reg   <= out_high_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_high_reg, out_low_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRSM_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "entry count exceeds capacity")
    `SRSM_ASSERT_IMP(a_emit_free, emit, out_free,
        "result loaded while the output register still holds a transaction")
    `SRSM_ASSERT_NXT(a_accept_busy, s_accept, state_reg != S_IDLE,
        "controller still idle after accepting a transaction")

endmodule

`default_nettype wire

FILE: rtl/core/srsm_cell.sv
// ----------------------------------------------------------------------------
// Sorted range set merger cell
// Holds one range of the sorted table and moves it to or from its neighbors
// on insert, shift and delete commands.
// ----------------------------------------------------------------------------
`default_nettype none

module srsm_cell
    import srsm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int IDX        = 0
)
(
    input  wire logic                               clk,
    input  wire cell_op_t                           op,
    input  wire logic [$clog2(CAPACITY + 1) - 1:0]  count,
    input  wire logic [VALUE_BITS-1:0]              key,
    input  wire logic [VALUE_BITS-1:0]              key_high,
    input  wire logic [VALUE_BITS-1:0]              prev_low,
    input  wire logic [VALUE_BITS-1:0]              prev_high,
    input  wire logic                               prev_after,
    input  wire logic [VALUE_BITS-1:0]              next_low,
    input  wire logic [VALUE_BITS-1:0]              next_high,
    output logic      [VALUE_BITS-1:0]              low,
    output logic      [VALUE_BITS-1:0]              high,
    output cell_flags_t                             flags
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [VALUE_BITS-1:0] low_reg;
    logic [VALUE_BITS-1:0] low_next;
    logic [VALUE_BITS-1:0] high_reg;
    logic [VALUE_BITS-1:0] high_next;

    // The table is sorted, so "after" is false up to the insert point and
    // true from there on; the first true cell takes the new range.
    always_comb
    begin
        flags.after = (MY_IDX >= count) || (low_reg > key);
        flags.match = (MY_IDX < count) && (low_reg == key);
    end

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        case (op)
            CELL_INSERT:
            begin
                if (flags.after && !prev_after)
                begin
                    low_next  = key;
                    high_next = key_high;
                end
                else if (flags.after)
                begin
                    low_next  = prev_low;
                    high_next = prev_high;
                end
            end
            CELL_SHIFT:
            begin
                low_next  = next_low;
                high_next = next_high;
            end
            CELL_DELETE:
            begin
                // Matches are contiguous, so every cell from the first match
                // on closes the gap left by removing that match.
                if (low_reg >= key)
                begin
                    low_next  = next_low;
                    high_next = next_high;
                end
            end
            default:
            begin
                low_next  = low_reg;
                high_next = high_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
    end

    assign low  = low_reg;
    assign high = high_reg;

endmodule

`default_nettype wire
